[hdl/mvsm_pkg.sv]
// shared types and constants for the multi-voice sample mixer
`timescale 1ns / 1ps
`default_nettype none

package mvsm_pkg;

   // sizing (sample depth must be a power of two)
   localparam int MAX_VOICES   = 16;
   localparam int SAMPLE_DEPTH = 65536;
   localparam int NUM_WAVES    = 16;

   localparam int VOICE_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int WAVE_AW   = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
   localparam int SAMPLE_AW = $clog2(SAMPLE_DEPTH);

   // base plus position is at most 18 bits wide
   localparam int ADDR_SUM_W = (SAMPLE_AW > 18) ? SAMPLE_AW : 18;

   localparam int POS_W  = 17;
   localparam int PROD_W = 33;
   localparam int ACC_W  = PROD_W + VOICE_W + 2;

   localparam int ROUND_BIAS = 8192;
   localparam int FRAC_SHIFT = 14;
   localparam int SUM_MAX    = 8388607;
   localparam int SUM_MIN    = -8388608;

   typedef enum logic [1:0] {
      MODE_WRITE_SAMPLE = 2'd0,
      MODE_SET_WAVE     = 2'd1,
      MODE_START_VOICE  = 2'd2,
      MODE_RENDER       = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [15:0]        sample_address;
      logic signed [15:0] sample_value;
      logic [3:0]         wave_id;
      logic [15:0]        wave_base;
      logic [16:0]        wave_length;
      logic [15:0]        volume;
      logic               loop_flag;
   } req_type;

   typedef struct packed {
      logic signed [23:0] left_sum;
      logic signed [23:0] right_sum;
      logic               start_accepted;
      logic               clipped;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/multi_voice_sample_mixer_unit.sv]
// top level of the multi-voice sample mixer: sequencer, voice table, sample memory, mac
`timescale 1ns / 1ps
`default_nettype none

// modes 0 to 2 answer in the cycle after the transaction, busy stays low
// render: busy through ST_RENDER, one voice per cycle through the sample memory read
// port and the single shared multiplier, then ST_FLUSH_A, ST_FLUSH_B and ST_FINISH
// for rounding and saturation; the result strobes on the cycle busy drops
// reset: synchronous, clears voices and wave table; sample memory is not cleared
// results are strobed for one cycle, the receiver cannot stall
module multi_voice_sample_mixer_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mvsm_pkg::req_type req_payload,
   output logic                  rsp_strobe,
   output mvsm_pkg::rsp_type     rsp_payload
);
   import mvsm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_RENDER  = 5'b00010,
      ST_FLUSH_A = 5'b00100,
      ST_FLUSH_B = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [VOICE_W-1:0] cnt_ff, cnt_in;

   // wave descriptor table
   logic [15:0]      wave_start_ff [NUM_WAVES];
   logic [POS_W-1:0] wave_size_ff  [NUM_WAVES];

   // voice slots
   logic               voice_active_ff   [MAX_VOICES];
   logic [WAVE_AW-1:0] voice_wave_ff     [MAX_VOICES];
   logic [POS_W-1:0]   voice_position_ff [MAX_VOICES];
   logic [15:0]        voice_gain_ff     [MAX_VOICES];
   logic               voice_repeats_ff  [MAX_VOICES];

   // sample memory, one write and one registered read port
   logic [15:0] sample_mem [SAMPLE_DEPTH];
   logic [15:0] rd_data_ff;
   logic [SAMPLE_AW-1:0] rd_addr, wr_addr;
   logic mem_we;

   // mac pipeline
   logic                     s1_ff, s2_ff;
   logic [15:0]              s1_gain_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_strobe_ff;

   // transaction decode
   logic accept;
   logic id_ok;
   logic [WAVE_AW-1:0] id_idx;
   logic [ADDR_SUM_W-1:0] wr_addr_ext;

   // free-slot search for voice start
   logic               free_found;
   logic [VOICE_W-1:0] free_idx;

   // per-voice render step
   logic [VOICE_W-1:0] vi;
   logic [WAVE_AW-1:0] vw;
   logic [POS_W-1:0]   v_size, v_pos, pos_adv, pos_next;
   logic               v_hit, v_end, v_active_next;
   logic [ADDR_SUM_W-1:0] addr_sum;

   // rounding and saturation
   logic signed [ACC_W-1:0]            acc_round, acc_shift;
   logic signed [ACC_W-FRAC_SHIFT-1:0] frame_sum;
   logic signed [23:0]                 sat_sum;
   logic                               sat_clip;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   assign id_ok  = ({28'd0, req_payload.wave_id} < 32'(NUM_WAVES));
   assign id_idx = WAVE_AW'(req_payload.wave_id);

   assign wr_addr_ext = ADDR_SUM_W'(req_payload.sample_address);
   assign wr_addr     = wr_addr_ext[SAMPLE_AW-1:0];
   assign mem_we      = accept && (req_payload.mode == MODE_WRITE_SAMPLE);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = MAX_VOICES - 1; k >= 0; k--) begin
         if (!voice_active_ff[k]) begin
            free_found = 1'b1;
            free_idx   = VOICE_W'(k);
         end
      end
   end

   // one voice per cycle: fetch, advance, wrap or free
   assign vi     = cnt_ff;
   assign vw     = voice_wave_ff[vi];
   assign v_size = wave_size_ff[vw];
   assign v_pos  = voice_position_ff[vi];
   assign v_hit  = voice_active_ff[vi] && (v_pos < v_size);
   assign pos_adv = v_hit ? (v_pos + POS_W'(1)) : v_pos;
   assign v_end   = (pos_adv >= v_size);
   assign pos_next      = (v_end && voice_repeats_ff[vi]) ? '0 : pos_adv;
   assign v_active_next = voice_active_ff[vi] && !(v_end && !voice_repeats_ff[vi]);

   assign addr_sum = ADDR_SUM_W'(wave_start_ff[vw]) + ADDR_SUM_W'(v_pos);
   assign rd_addr  = addr_sum[SAMPLE_AW-1:0];

   // round half up, floor by 2^14, saturate to 24 bits
   assign acc_round = acc_ff + ACC_W'(ROUND_BIAS);
   assign acc_shift = acc_round >>> FRAC_SHIFT;
   assign frame_sum = acc_shift[ACC_W-FRAC_SHIFT-1:0];

   always_comb begin
      sat_clip = 1'b0;
      sat_sum  = frame_sum[23:0];
      if (frame_sum > (ACC_W-FRAC_SHIFT)'(SUM_MAX)) begin
         sat_sum  = 24'(SUM_MAX);
         sat_clip = 1'b1;
      end else if (frame_sum < (ACC_W-FRAC_SHIFT)'(SUM_MIN)) begin
         sat_sum  = 24'(SUM_MIN);
         sat_clip = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_payload.mode == MODE_RENDER)) begin
               state_in = ST_RENDER;
               cnt_in   = '0;
            end
         end
         ST_RENDER: begin
            if (cnt_ff == VOICE_W'(MAX_VOICES - 1)) begin
               state_in = ST_FLUSH_A;
            end else begin
               cnt_in = cnt_ff + VOICE_W'(1);
            end
         end
         ST_FLUSH_A: state_in = ST_FLUSH_B;
         ST_FLUSH_B: state_in = ST_FINISH;
         ST_FINISH:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_in = '0;
      if (state_ff == ST_FINISH) begin
         rsp_in.left_sum  = sat_sum;
         rsp_in.right_sum = sat_sum;
         rsp_in.clipped   = sat_clip;
      end else if (accept && (req_payload.mode == MODE_START_VOICE)) begin
         rsp_in.start_accepted = id_ok && free_found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         s1_ff         <= 1'b0;
         s2_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= (state_ff == ST_FINISH) ||
                          (accept && (req_payload.mode != MODE_RENDER));
         s1_ff         <= (state_ff == ST_RENDER) && v_hit;
         s2_ff         <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      s1_gain_ff <= voice_gain_ff[vi];
      prod_ff    <= $signed(rd_data_ff) * $signed({1'b0, s1_gain_ff});
      if (accept) begin
         acc_ff <= '0;
      end else if (s2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // wave descriptors
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WAVES; w++) begin
            wave_start_ff[w] <= '0;
            wave_size_ff[w]  <= '0;
         end
      end else if (accept && (req_payload.mode == MODE_SET_WAVE) && id_ok) begin
         wave_start_ff[id_idx] <= req_payload.wave_base;
         wave_size_ff[id_idx]  <= req_payload.wave_length;
      end
   end

   // voice slots: start writes the free slot, render rewrites the current one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_VOICES; k++) begin
            voice_active_ff[k]   <= 1'b0;
            voice_wave_ff[k]     <= '0;
            voice_position_ff[k] <= '0;
            voice_gain_ff[k]     <= '0;
            voice_repeats_ff[k]  <= 1'b0;
         end
      end else if (accept && (req_payload.mode == MODE_START_VOICE) && id_ok && free_found) begin
         voice_active_ff[free_idx]   <= 1'b1;
         voice_wave_ff[free_idx]     <= id_idx;
         voice_position_ff[free_idx] <= '0;
         voice_gain_ff[free_idx]     <= req_payload.volume;
         voice_repeats_ff[free_idx]  <= req_payload.loop_flag;
      end else if (state_ff == ST_RENDER) begin
         voice_active_ff[vi]   <= v_active_next;
         voice_position_ff[vi] <= pos_next;
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[wr_addr] <= req_payload.sample_value;
      end
      rd_data_ff <= sample_mem[rd_addr];
   end

endmodule

`default_nettype wire
